// ===== hdl/pip_pkg.sv =====
package pip_pkg;

  localparam int unsigned LAT_W          = 28;
  localparam int unsigned LON_W          = 29;
  localparam int unsigned IDX_W          = 9;
  localparam int unsigned CNT_W          = 10;
  localparam int unsigned MAX_POINTS_DEF = 512;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } vertex_t;

  typedef struct packed {
    logic busy;
    logic parity;
  } pip_edge_stat_t;

endpackage

// ===== hdl/pip_in_if.sv =====
interface pip_in_if import pip_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;

  modport source (
    output valid, mode, vertex_index, latitude, longitude,
    input  ready
  );

  modport sink (
    input  valid, mode, vertex_index, latitude, longitude,
    output ready
  );

endinterface

// ===== hdl/pip_out_if.sv =====
interface pip_out_if import pip_pkg::*; ();

  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );

  modport sink (
    input  valid, inside_res,
    output ready
  );

endinterface

// ===== hdl/pip_edge_unit.sv =====
module pip_edge_unit import pip_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           vtx_valid_i,
  input  logic           vtx_first_i,
  input  vertex_t        vtx_i,
  input  vertex_t        qry_i,
  output pip_edge_stat_t stat_o
);

  localparam int unsigned PW = LAT_W + LON_W + 2;

  vertex_t prev_q;

  logic                    s2_vld_q;
  logic signed [LAT_W:0]   s2_dlat_q;
  logic signed [LAT_W:0]   s2_qlat_q;
  logic signed [LON_W:0]   s2_qlon_q;
  logic signed [LON_W:0]   s2_jlon_q;

  logic                    s3_vld_q;
  logic                    s3_neg_q;
  logic signed [PW-1:0]    s3_lhs_q;
  logic signed [PW-1:0]    s3_rhs_q;

  logic                    parity_q;

  logic                    straddle;
  logic signed [LAT_W:0]   dlat;
  logic signed [LAT_W:0]   qlat;
  logic signed [LON_W:0]   qlon;
  logic signed [LON_W:0]   jlon;
  logic                    flip;

  always_comb begin
    straddle = (vtx_i.lat > qry_i.lat) != (prev_q.lat > qry_i.lat);
    dlat     = (LAT_W+1)'(prev_q.lat) - (LAT_W+1)'(vtx_i.lat);
    qlat     = (LAT_W+1)'(qry_i.lat) - (LAT_W+1)'(vtx_i.lat);
    qlon     = (LON_W+1)'(qry_i.lon) - (LON_W+1)'(vtx_i.lon);
    jlon     = (LON_W+1)'(prev_q.lon) - (LON_W+1)'(vtx_i.lon);
    flip     = s3_vld_q && (s3_neg_q ? (s3_lhs_q > s3_rhs_q) : (s3_lhs_q < s3_rhs_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      s2_vld_q <= vtx_valid_i && !vtx_first_i && straddle;
      s3_vld_q <= s2_vld_q;
      if (start_i) begin
        parity_q <= 1'b0;
      end else if (flip) begin
        parity_q <= !parity_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_valid_i) begin
      prev_q    <= vtx_i;
      s2_dlat_q <= dlat;
      s2_qlat_q <= qlat;
      s2_qlon_q <= qlon;
      s2_jlon_q <= jlon;
    end
    s3_neg_q <= s2_dlat_q[LAT_W];
    s3_lhs_q <= PW'(s2_qlon_q) * PW'(s2_dlat_q);
    s3_rhs_q <= PW'(s2_jlon_q) * PW'(s2_qlat_q);
  end

  assign stat_o.busy   = s2_vld_q || s3_vld_q;
  assign stat_o.parity = parity_q;

endmodule

// ===== hdl/point_in_polygon_test.sv =====
// Even-odd point-in-polygon test against one ring held in vertex memory.
// Input channel in_i carries one word per item: mode 0 stores latitude and
// longitude at vertex_index (slots at or above MAX_POINTS are dropped);
// mode 1 tests the point latitude/longitude against the stored ring.
// Output channel out_o carries inside_res, one word per query, none per write.
// cfg_we_i/cfg_wdata_i set ring_count, the number of vertices a query walks;
// counts above MAX_POINTS saturate. Write it only while the block is idle.
// A query reads one vertex per cycle from the single-port vertex memory:
// the saturated ring_count + 1 reads, then edge arithmetic (difference,
// multiply, compare); a count of zero reads nothing and goes straight to
// the result. The memory port sets the pace; in_i is not ready while a
// query walks the ring.
// The result sits in an output register: in_i takes new words while it waits,
// and a finished query holds until out_o is free again.
// Reset clears ring_count and all handshake state; vertex memory is left as
// is and must be written before a query reads it.
module point_in_polygon_test import pip_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pip_in_if.sink           in_i,
  pip_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] ring_count_q;
  logic [CW-1:0]    n_q, n_d;
  logic [CW-1:0]    rd_cnt_q, rd_cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic             rd_first_q, rd_first_d;
  vertex_t          rd_q;
  vertex_t          qry_q;
  logic             out_valid_q;
  logic             out_res_q;

  vertex_t          ring_mem [MAX_POINTS];

  logic             in_acc;
  logic             wr_en;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    n_sat;
  logic             start;
  logic             load_out;
  pip_edge_stat_t   stat;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign wr_en      = in_acc && (in_i.mode == MODE_WRITE) &&
                      (32'(in_i.vertex_index) < MAX_POINTS);
  assign start      = in_acc && (in_i.mode == MODE_QUERY);
  assign n_sat      = (32'(ring_count_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(ring_count_q);
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    rd_cnt_d   = rd_cnt_q;
    rd_vld_d   = 1'b0;
    rd_first_d = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = rd_cnt_q[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          n_d      = n_sat;
          rd_cnt_d = '0;
          if (n_sat == '0) begin
            state_d = ST_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = AW'(n_sat - CW'(1));
            rd_vld_d   = 1'b1;
            rd_first_d = 1'b1;
            state_d    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (rd_cnt_q != n_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_cnt_d = rd_cnt_q + CW'(1);
        end else if (!rd_vld_q && !stat.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ring_count_q <= '0;
      n_q          <= '0;
      rd_cnt_q     <= '0;
      rd_vld_q     <= 1'b0;
      rd_first_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      rd_cnt_q   <= rd_cnt_d;
      rd_vld_q   <= rd_vld_d;
      rd_first_q <= rd_first_d;
      if (cfg_we_i) begin
        ring_count_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[AW'(in_i.vertex_index)] <= '{lat: in_i.latitude, lon: in_i.longitude};
    end
    if (rd_en) begin
      rd_q <= ring_mem[rd_addr];
    end
    if (start) begin
      qry_q <= '{lat: in_i.latitude, lon: in_i.longitude};
    end
    if (load_out) begin
      out_res_q <= stat.parity;
    end
  end

  pip_edge_unit u_edge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .vtx_valid_i (rd_vld_q),
    .vtx_first_i (rd_first_q),
    .vtx_i       (rd_q),
    .qry_i       (qry_q),
    .stat_o      (stat)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = out_res_q;

  a_idle_drained: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!rd_vld_q && !stat.busy)
  ) else $error("vertex pipeline busy while idle");

  a_cnt_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rd_cnt_q <= n_q && n_q != '0)
  ) else $error("read counter beyond ring count");

  a_out_from_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE)
  ) else $error("result raised outside completion");

  a_done_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (state_q == ST_IDLE || state_q == ST_DONE)
  ) else $error("completion left to a bad state");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pip_pkg::*;

  localparam int LAT_MIN     = -(1 << (LAT_W - 1));
  localparam int LAT_MAX     = (1 << (LAT_W - 1)) - 1;
  localparam int LON_MIN     = -(1 << (LON_W - 1));
  localparam int LON_MAX     = (1 << (LON_W - 1)) - 1;
  localparam int CYCLE_LIMIT = 2000000;

  class ring_scoreboard;
    longint          slot_lat[MAX_POINTS_DEF];
    longint          slot_lon[MAX_POINTS_DEF];
    bit [CNT_W-1:0]  ring_count;
    bit              inside_due[$];
    int              errors;

    function int walk_length();
      return (ring_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(ring_count);
    endfunction

    function void load_ring_count(bit [CNT_W-1:0] value);
      ring_count = value;
    endfunction

    function bit crosses_west(longint kla, longint klo, longint jla, longint jlo,
                              longint qla, longint qlo);
      longint d;
      longint lhs;
      longint rhs;
      if ((kla > qla) == (jla > qla)) return 1'b0;
      d   = jla - kla;
      lhs = (qlo - klo) * d;
      rhs = (jlo - klo) * (qla - kla);
      return (d > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function bit point_inside(longint qla, longint qlo);
      int n;
      int j;
      bit parity;
      n = walk_length();
      parity = 1'b0;
      j = n - 1;
      for (int k = 0; k < n; k++) begin
        if (crosses_west(slot_lat[k], slot_lon[k], slot_lat[j], slot_lon[j], qla, qlo))
          parity = !parity;
        j = k;
      end
      return parity;
    endfunction

    function void note_word(logic mode, logic [IDX_W-1:0] idx,
                            logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
      longint qla;
      longint qlo;
      qla = lat;
      qlo = lon;
      if (mode == MODE_WRITE) begin
        slot_lat[idx] = qla;
        slot_lon[idx] = qlo;
      end else begin
        inside_due = {inside_due, point_inside(qla, qlo)};
      end
    endfunction

    function void check_result(logic inside_res);
      bit want;
      if (inside_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result inside_res=%b", $time, inside_res);
        return;
      end
      want = inside_due.pop_front();
      if (inside_res !== want) begin
        errors++;
        $display("%0t: inside_res mismatch expected=%b actual=%b", $time, want, inside_res);
      end
    endfunction

    function int pending();
      return inside_due.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  pip_in_if  in_if ();
  pip_out_if out_if ();

  ring_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  int ring_lat[MAX_POINTS_DEF];
  int ring_lon[MAX_POINTS_DEF];
  int ring_clat;
  int ring_clon;
  int ring_span;

  point_in_polygon_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_word(in_if.mode, in_if.vertex_index, in_if.latitude, in_if.longitude);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.inside_res);
      if (cfg_we)
        sb.load_ring_count(cfg_wdata);
    end
  end

  function automatic int rand_around(int center, int span);
    return center + int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int extreme_lat();
    case ($urandom_range(3))
      0:       return LAT_MIN;
      1:       return LAT_MAX;
      2:       return -90000000;
      default: return 90000000;
    endcase
  endfunction

  function automatic int extreme_lon();
    case ($urandom_range(3))
      0:       return LON_MIN;
      1:       return LON_MAX;
      2:       return -180000000;
      default: return 180000000;
    endcase
  endfunction

  task automatic send_word(input logic m, input logic [IDX_W-1:0] idx,
                           input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= m;
    in_if.vertex_index <= idx;
    in_if.latitude     <= lat;
    in_if.longitude    <= lon;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic write_vertex(input int idx, input int lat, input int lon);
    ring_lat[idx] = lat;
    ring_lon[idx] = lon;
    send_word(MODE_WRITE, idx[IDX_W-1:0], lat[LAT_W-1:0], lon[LON_W-1:0]);
  endtask

  task automatic query_point(input int lat, input int lon);
    logic [IDX_W-1:0] junk;
    junk = IDX_W'($urandom);
    send_word(MODE_QUERY, junk, lat[LAT_W-1:0], lon[LON_W-1:0]);
  endtask

  // drop valid, drain results, then let the walk finish before touching config
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (sb.walk_length() + 8) @(posedge clk_i);
  endtask

  task automatic set_ring_count(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_ring(input int n);
    int lat;
    int lon;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(3) == 0) lat = ring_lat[i - 1];
      else if ($urandom_range(15) == 0)    lat = $urandom;
      else                                 lat = rand_around(ring_clat, ring_span);
      if ($urandom_range(15) == 0) lon = $urandom;
      else                         lon = rand_around(ring_clon, ring_span);
      write_vertex(i, lat, lon);
    end
  endtask

  task automatic random_query(input int n);
    int k;
    int wide;
    k = $urandom_range(((n > MAX_POINTS_DEF) ? MAX_POINTS_DEF : ((n > 0) ? n : 1)) - 1);
    wide = ring_span + ring_span / 4;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: query_point(rand_around(ring_clat, wide), rand_around(ring_clon, wide));
      5, 6:          query_point(ring_lat[k], rand_around(ring_clon, wide));
      7:             query_point(ring_lat[k], ring_lon[k]);
      8:             query_point($urandom, $urandom);
      default:       query_point(extreme_lat(), extreme_lon());
    endcase
  endtask

  task automatic run_phase(input int p);
    int n;
    int queries;
    case (p % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
    case (p)
      1:       n = 1;
      2:       n = 2;
      3:       n = 3;
      5:       n = 0;
      9:       n = MAX_POINTS_DEF;
      10:      n = (1 << CNT_W) - 1;
      11:      n = $urandom_range((1 << CNT_W) - 2, MAX_POINTS_DEF + 1);
      default: n = $urandom_range(24, 4);
    endcase
    if (n > 0 && n <= MAX_POINTS_DEF) begin
      case ($urandom_range(3))
        0:       ring_span = 8;
        1:       ring_span = 1000;
        2:       ring_span = 2000000;
        default: ring_span = 60000000;
      endcase
      ring_clat = rand_around(0, 80000000);
      ring_clon = rand_around(0, 170000000);
      write_ring(n);
    end
    wait_idle();
    set_ring_count(n);
    queries = (n > 24) ? 12 : 18;
    repeat (queries) begin
      if ($urandom_range(7) == 0)
        write_vertex($urandom_range(MAX_POINTS_DEF - 1), $urandom, $urandom);
      random_query(n);
    end
    wait_idle();
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_if.valid        <= 1'b0;
    in_if.mode         <= MODE_WRITE;
    in_if.vertex_index <= '0;
    in_if.latitude     <= '0;
    in_if.longitude    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring answers outside
    query_point(0, 0);
    query_point(LAT_MAX, LON_MIN);

    // full-scale square with two horizontal edges
    write_vertex(0, LAT_MIN, LON_MIN);
    write_vertex(1, LAT_MIN, LON_MAX);
    write_vertex(2, LAT_MAX, LON_MAX);
    write_vertex(3, LAT_MAX, LON_MIN);
    write_vertex(MAX_POINTS_DEF - 1, 90000000, 180000000);
    wait_idle();
    set_ring_count(4);
    query_point(0, 0);
    query_point(LAT_MIN, 0);
    query_point(LAT_MAX, 0);
    query_point(0, LON_MIN);
    query_point(0, LON_MAX);
    query_point(-90000000, -180000000);
    query_point(90000000, 180000000);
    query_point(LAT_MAX - 1, LON_MAX - 1);
    wait_idle();

    for (int p = 0; p < 12; p++) run_phase(p);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
